[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the raster to RGBA converter.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/bmp2rgba_pkg.sv]
// Shared types and constants for the BMP raster to RGBA converter.
// No dependencies; imported by the top level, bmp2rgba_ctrl and bmp2rgba_emit.
package bmp2rgba_pkg;

    localparam int ROW_WIDTH_W = 13;
    localparam int POS_W       = 14;
    localparam int CFG_DATA_W  = 13;

    // configuration register indexes
    localparam logic CFG_PIXEL_DEPTH = 1'b0;
    localparam logic CFG_ROW_WIDTH   = 1'b1;

    // pixel depth codes
    localparam logic [1:0] DEPTH_4BPP  = 2'd0;
    localparam logic [1:0] DEPTH_8BPP  = 2'd1;
    localparam logic [1:0] DEPTH_24BPP = 2'd2;
    localparam logic [1:0] DEPTH_NONE  = 2'd3;

    // input item kinds
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_RASTER  = 1'b1;

    localparam logic [1:0]  RESET_DEPTH = DEPTH_8BPP;
    localparam logic [12:0] RESET_WIDTH = 13'd32;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [23:0] RGB_WHITE    = 24'hFFFFFF;
    localparam logic [23:0] RGB_KEY      = 24'h00FF00;

    // what one raster byte turns into, pending palette data
    typedef struct packed {
        logic        has_pix;
        logic        two;       // 4 bpp byte giving two pixels
        logic        lookup0;   // first pixel comes from the palette
        logic [23:0] rgb0;      // first pixel color when not looked up
        logic [7:0]  alpha0;
        logic        rend0;
        logic        rend1;
    } pix_desc_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] alpha;
        logic       last;
        logic       rend;
    } pixel_t;

endpackage

[hw/rtl/bmp_raster_to_rgba_unit.sv]
// Top level of the BMP raster to RGBA converter: config registers and glue.
// Depends on bmp2rgba_pkg, assert_macros.svh, bmp2rgba_pal, bmp2rgba_ctrl, bmp2rgba_emit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per byte-sized item:
//   mode 0 writes pal_color into palette entry pal_index, mode 1 carries a raster
//   byte. Output channel (out_valid/out_ready) carries one RGBA pixel per
//   transaction, with last_of_run on the final pixel of an input byte and
//   row_end on the last pixel of a row. Row padding bytes give no pixels.
//   Config port: cfg_we writes cfg_data into pixel_depth (index 0) or
//   row_width (index 1); write only while the block is idle.
//   Pipeline: a taken byte is registered in the decode stage along with its
//   palette read, then moves to the output register.
//   Throughput: one input byte per cycle while the output is not stalled; a 4 bpp
//   byte yielding two pixels holds the decode stage until its second pixel has
//   moved on, since the output register moves one pixel per cycle.
//   Reset: 8 bpp, width 32, row position zero; palette contents are undefined
//   until written.
//   Output stall: the output register holds one pixel, the decode stage one byte;
//   in_ready stays low while that byte's last pixel cannot enter the output register.
module bmp_raster_to_rgba_unit #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [bmp2rgba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  pal_index,
    input  logic [23:0] pal_color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_alpha,
    output logic        last_of_run,
    output logic        row_end
);
    import bmp2rgba_pkg::*;
    `include "assert_macros.svh"

    logic [1:0]             pixel_depth_reg, pixel_depth_next;
    logic [ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic                   take, take_raster, take_pal, s1_free;
    logic [7:0]             raddr0;
    logic [23:0]            rd0, rd1;
    pix_desc_t              desc;
    pixel_t                 pix;

    always_comb
    begin
        pixel_depth_next = pixel_depth_reg;
        row_width_next   = row_width_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_DEPTH: pixel_depth_next = cfg_data[1:0];
                CFG_ROW_WIDTH:   row_width_next   = cfg_data[ROW_WIDTH_W-1:0];
                default:         pixel_depth_next = pixel_depth_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_depth_reg <= RESET_DEPTH;
            row_width_reg   <= RESET_WIDTH;
        end
        else
        begin
            pixel_depth_reg <= pixel_depth_next;
            row_width_reg   <= row_width_next;
        end
    end

    assign in_ready    = s1_free;
    assign take        = in_valid && in_ready;
    assign take_raster = take && (mode == MODE_RASTER);
    assign take_pal    = take && (mode == MODE_PALETTE);
    assign raddr0      = (pixel_depth_reg == DEPTH_4BPP) ? {4'h0, data_byte[7:4]} : data_byte;

    bmp2rgba_pal #(
        .DEPTH (PALETTE_DEPTH)
    ) u_pal (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (take_pal),
        .waddr  (pal_index),
        .wdata  (pal_color),
        .re     (take_raster),
        .raddr0 (raddr0),
        .raddr1 ({4'h0, data_byte[3:0]}),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    bmp2rgba_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take_raster (take_raster),
        .data_byte   (data_byte),
        .pixel_depth (pixel_depth_reg),
        .row_width   (row_width_reg),
        .desc        (desc)
    );

    bmp2rgba_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .desc_in   (desc),
        .rd0       (rd0),
        .rd1       (rd1),
        .out_ready (out_ready),
        .s1_free   (s1_free),
        .out_valid (out_valid),
        .pix       (pix)
    );

    assign out_byte0   = pix.byte0;
    assign out_byte1   = pix.byte1;
    assign out_byte2   = pix.byte2;
    assign out_alpha   = pix.alpha;
    assign last_of_run = pix.last;
    assign row_end     = pix.rend;

    // first half of a 4 bpp pair is always followed at once by the second
    `ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid && last_of_run)
    // a row never ends mid-byte
    `ASSERT_ALWAYS(a_rend_last, clk, rst_n, !out_valid || !row_end || last_of_run)
    // transparent pixels only come from the index-zero white or the 24 bpp key
    `ASSERT_ALWAYS(a_clear_color, clk, rst_n, !out_valid || out_alpha != ALPHA_CLEAR || {out_byte2, out_byte1, out_byte0} == RGB_WHITE || {out_byte2, out_byte1, out_byte0} == 24'h000000)

endmodule

[hw/rtl/bmp2rgba_pal.sv]
// Palette store: one write port, two registered read ports.
// Depends on nothing outside the module; instantiated by the top level.
module bmp2rgba_pal #(
    parameter int DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [7:0]  waddr,
    input  logic [23:0] wdata,
    input  logic        re,
    input  logic [7:0]  raddr0,
    input  logic [7:0]  raddr1,
    output logic [23:0] rdata0,
    output logic [23:0] rdata1
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] DEPTH_C = 9'(DEPTH);

    logic [23:0] mem [DEPTH];
    logic [23:0] rd0_reg;
    logic [23:0] rd1_reg;
    logic        oob0_reg;
    logic        oob0_next;
    logic        wr_ok;
    logic        rd0_ok;

    assign wr_ok  = {1'b0, waddr} < DEPTH_C;
    assign rd0_ok = {1'b0, raddr0} < DEPTH_C;

    always_comb
    begin
        oob0_next = oob0_reg;
        if (re)
        begin
            oob0_next = !rd0_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && wr_ok)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
    end

    // second port only sees nibbles and, unlike the first, has no out-of-range check
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd0_reg <= mem[raddr0[AW-1:0]];
            rd1_reg <= mem[raddr1[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oob0_reg <= 1'b0;
        end
        else
        begin
            oob0_reg <= oob0_next;
        end
    end

    assign rdata0 = oob0_reg ? 24'h000000 : rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

[hw/rtl/bmp2rgba_ctrl.sv]
// Row position tracking and per-byte pixel decode for the raster stream.
// Depends on bmp2rgba_pkg; instantiated by the top level.
module bmp2rgba_ctrl #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take_raster,
    input  logic [7:0]                    data_byte,
    input  logic [1:0]                    pixel_depth,
    input  logic [bmp2rgba_pkg::ROW_WIDTH_W-1:0] row_width,
    output bmp2rgba_pkg::pix_desc_t       desc
);
    import bmp2rgba_pkg::*;

    localparam int LW     = $clog2(3 * MAX_WIDTH + 2);
    localparam int CALC_W = (LW > POS_W) ? LW : POS_W;
    localparam logic [CALC_W-1:0] MAX_W_C = CALC_W'(MAX_WIDTH);
    localparam logic [CALC_W-1:0] ONE_C   = CALC_W'(1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       partial_reg, partial_next;

    logic [CALC_W-1:0] rw_ext, w, wm1, payload, line, pos_raw, pos, pos_inc, pos_n;
    logic [CALC_W-1:0] px, px1;
    logic [1:0]        phase, phase_inc;
    logic              wrap, in_pay, active;
    logic [23:0]       rgb24;

    always_comb
    begin
        rw_ext = CALC_W'(row_width);
        if (rw_ext == '0)
        begin
            w = ONE_C;
        end
        else if (rw_ext > MAX_W_C)
        begin
            w = MAX_W_C;
        end
        else
        begin
            w = rw_ext;
        end
        wm1 = w - ONE_C;

        unique case (pixel_depth)
            DEPTH_4BPP:  payload = (w + ONE_C) >> 1;
            DEPTH_8BPP:  payload = w;
            DEPTH_24BPP: payload = (w << 1) + w;
            default:     payload = w;
        endcase
        line = (payload + ONE_C) & ~ONE_C;

        pos_raw = CALC_W'(pos_reg);
        wrap    = pos_raw >= line;
        pos     = wrap ? '0 : pos_raw;
        phase   = wrap ? 2'd0 : phase_reg;
        in_pay  = pos < payload;
        px      = pos << 1;
        px1     = px + ONE_C;
        rgb24   = {data_byte, partial_reg};

        pos_inc   = pos + ONE_C;
        pos_n     = (pos_inc >= line) ? '0 : pos_inc;
        phase_inc = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
        active    = take_raster && (pixel_depth != DEPTH_NONE);

        desc         = '0;
        desc.alpha0  = ALPHA_OPAQUE;
        partial_next = partial_reg;

        if (in_pay)
        begin
            unique case (pixel_depth)
                DEPTH_8BPP:
                begin
                    desc.has_pix = 1'b1;
                    desc.rend0   = pos == wm1;
                    if (data_byte == 8'h00)
                    begin
                        desc.rgb0   = RGB_WHITE;
                        desc.alpha0 = ALPHA_CLEAR;
                    end
                    else
                    begin
                        desc.lookup0 = 1'b1;
                    end
                end
                DEPTH_4BPP:
                begin
                    desc.has_pix = 1'b1;
                    desc.lookup0 = 1'b1;
                    desc.two     = px1 < w;
                    desc.rend0   = px == wm1;
                    desc.rend1   = px1 == wm1;
                end
                DEPTH_24BPP:
                begin
                    if (phase == 2'd0)
                    begin
                        partial_next = {8'h00, data_byte};
                    end
                    else if (phase == 2'd1)
                    begin
                        partial_next = {data_byte, partial_reg[7:0]};
                    end
                    else
                    begin
                        desc.has_pix = 1'b1;
                        desc.rend0   = pos == payload - ONE_C;
                        if (rgb24 == RGB_KEY)
                        begin
                            desc.alpha0 = ALPHA_CLEAR;
                        end
                        else
                        begin
                            desc.rgb0 = rgb24;
                        end
                    end
                end
                default:
                begin
                    desc.has_pix = 1'b0;
                end
            endcase
        end

        if (!active)
        begin
            desc.has_pix = 1'b0;
            partial_next = partial_reg;
        end

        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (active)
        begin
            pos_next   = pos_n[POS_W-1:0];
            phase_next = (pos_next == '0) ? 2'd0 : phase_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= 2'd0;
            partial_reg <= 16'h0000;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
        end
    end

endmodule

[hw/rtl/bmp2rgba_emit.sv]
// Decoded-byte holding stage and output register; splits 4 bpp bytes in two.
// Depends on bmp2rgba_pkg; instantiated by the top level.
module bmp2rgba_emit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  bmp2rgba_pkg::pix_desc_t   desc_in,
    input  logic [23:0]               rd0,
    input  logic [23:0]               rd1,
    input  logic                      out_ready,
    output logic                      s1_free,
    output logic                      out_valid,
    output bmp2rgba_pkg::pixel_t      pix
);
    import bmp2rgba_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    logic      s1_half_reg, s1_half_next;
    pix_desc_t s1_desc_reg, s1_desc_next;
    logic      out_valid_reg, out_valid_next;
    pixel_t    pix_reg, pix_next;
    pixel_t    pix_sel;
    logic      load_out, s1_release;
    logic [23:0] rgb_sel;

    always_comb
    begin
        load_out   = s1_valid_reg && (!out_valid_reg || out_ready);
        s1_release = load_out && (s1_half_reg || !s1_desc_reg.two);
        s1_free    = !s1_valid_reg || s1_release;

        if (s1_half_reg)
        begin
            rgb_sel       = rd1;
            pix_sel.alpha = ALPHA_OPAQUE;
            pix_sel.last  = 1'b1;
            pix_sel.rend  = s1_desc_reg.rend1;
        end
        else
        begin
            rgb_sel       = s1_desc_reg.lookup0 ? rd0 : s1_desc_reg.rgb0;
            pix_sel.alpha = s1_desc_reg.alpha0;
            pix_sel.last  = !s1_desc_reg.two;
            pix_sel.rend  = s1_desc_reg.rend0;
        end
        pix_sel.byte0 = rgb_sel[7:0];
        pix_sel.byte1 = rgb_sel[15:8];
        pix_sel.byte2 = rgb_sel[23:16];

        s1_valid_next = s1_valid_reg;
        s1_half_next  = s1_half_reg;
        s1_desc_next  = s1_desc_reg;
        if (load_out)
        begin
            s1_half_next = !s1_release;
        end
        if (s1_release)
        begin
            s1_valid_next = 1'b0;
        end
        if (take)
        begin
            s1_valid_next = desc_in.has_pix;
            s1_half_next  = 1'b0;
            s1_desc_next  = desc_in;
        end

        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            pix_next       = pix_sel;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_half_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_half_reg   <= s1_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_desc_reg <= s1_desc_next;
        pix_reg     <= pix_next;
    end

    assign out_valid = out_valid_reg;
    assign pix       = pix_reg;

endmodule
